// ===== sv/versatile_interface_port_subset_assert.svh =====
// assertion macros shared by the checker of the port subset block
// needs nothing but a clock and an active-low reset in the calling scope
`ifndef VERSATILE_INTERFACE_PORT_SUBSET_ASSERT_SVH
`define VERSATILE_INTERFACE_PORT_SUBSET_ASSERT_SVH

// same-cycle implication, off while reset is low
`define VIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define VIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define VIP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vip_pkg.sv =====
// types, register map and helpers for the port subset block
// used by every module of the block and by its checker; no dependencies
`timescale 1ns / 1ps

package vip_pkg;

    localparam logic [7:0] REG_RESET = 8'hff;
    localparam int         STORE_DEPTH = 16;

    // register map
    localparam logic [3:0] ADDR_PORT_B     = 4'd0;
    localparam logic [3:0] ADDR_PORT_A     = 4'd1;
    localparam logic [3:0] ADDR_DDR_B      = 4'd2;
    localparam logic [3:0] ADDR_DDR_A      = 4'd3;
    localparam logic [3:0] ADDR_PORT_A_ALT = 4'd15;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // port b bit roles
    localparam int PB_WRITE_BIT = 0;
    localparam int PB_READ_BIT  = 1;
    localparam int PB_READY_BIT = 2;
    localparam int PB_IRQ_BIT   = 3;

    // fields listed msb first, so the last field lands in the low bits
    typedef struct packed {
        logic [7:0] speech_status;
        logic       speech_irq;
        logic       speech_ready;
        logic [7:0] write_data;
        logic [3:0] reg_addr;
    } t_access;

    typedef struct packed {
        logic    mode;
        t_access acc;
    } t_item;

    typedef struct packed {
        logic       speech_read_strobe;
        logic [7:0] speech_write_data;
        logic       speech_write_strobe;
        logic [7:0] read_data;
    } t_result;

    localparam int ACC_W      = $bits(t_access);
    localparam int RES_W      = $bits(t_result);
    localparam int IN_TDATA_W = ((ACC_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int TUSER_W    = 1;

    function automatic logic [7:0] merge_bits(input logic [7:0] old_val,
                                              input logic [7:0] new_val,
                                              input logic [7:0] mask);
        return (old_val & ~mask) | (new_val & mask);
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_result(input t_result res);
        return {{(OUT_TDATA_W - RES_W){1'b0}}, res};
    endfunction

endpackage

// ===== sv/versatile_interface_port_subset.sv =====
// Port section of an interface adapter driving a speech chip: one bus read or
// write per stream word, one result word per access. A word is taken every
// clock while the result stream is not stalled; its result word passes the
// input register, then the result register, and the rate of one per cycle is
// set by the port, direction and storage registers updating as the word moves
// between those two registers. Reset is synchronous and needs no clearing pass.
// While a result waits to be taken, one more word is accepted into the input
// register; after that s_axis_tready stays low until the result is drained.
`timescale 1ns / 1ps

module versatile_interface_port_subset
    import vip_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // reg_addr[3:0], write_data[11:4], speech_ready[12], speech_irq[13],
    // speech_status[21:14], zero pad above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]: 0 read, 1 write
    input  logic [TUSER_W-1:0]     s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_data[7:0], speech_write_strobe[8], speech_write_data[16:9],
    // speech_read_strobe[17], zero pad above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    held_valid;
    t_item   held_item;
    logic    advance;
    t_result res;

    vip_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    vip_port_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (held_item),
        .o_res   (res)
    );

    vip_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_res     (res),
        .o_advance (advance),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// ===== sv/vip_in_stage.sv =====
// input register of the port subset block: holds one accepted bus word
// depends on vip_pkg
`timescale 1ns / 1ps

module vip_in_stage
    import vip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [TUSER_W-1:0]    i_tuser,
    input  logic                  i_advance,
    output logic                  o_valid,
    output t_item                 o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_tready = !r_valid || i_advance;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item.mode <= i_tuser[0];
            r_item.acc  <= t_access'(i_tdata[ACC_W-1:0]);
        end
    end

endmodule

// ===== sv/vip_port_regs.sv =====
// port and direction registers, plain storage and the access logic
// depends on vip_pkg; state moves only when the held word is retired
`timescale 1ns / 1ps

module vip_port_regs
    import vip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_res
);

    logic [7:0] r_pb, n_pb;
    logic [7:0] r_pa, n_pa;
    logic [7:0] r_db, n_db;
    logic [7:0] r_da, n_da;
    logic [STORE_DEPTH-1:0][7:0] r_store, n_store;

    t_access acc;
    assign acc = i_item.acc;

    always_comb begin
        n_pb    = r_pb;
        n_pa    = r_pa;
        n_db    = r_db;
        n_da    = r_da;
        n_store = r_store;
        o_res   = '0;
        if (i_item.mode == MODE_READ) begin
            case (acc.reg_addr)
                ADDR_PORT_B: begin
                    o_res.read_data = r_pb & r_db;
                    // a low ready or irq line reads back as a set bit
                    if (!acc.speech_ready) o_res.read_data[PB_READY_BIT] = 1'b1;
                    if (!acc.speech_irq) o_res.read_data[PB_IRQ_BIT] = 1'b1;
                end
                ADDR_PORT_A, ADDR_PORT_A_ALT: begin
                    o_res.read_data = r_pa & r_da;
                end
                ADDR_DDR_B: o_res.read_data = r_db;
                ADDR_DDR_A: o_res.read_data = r_da;
                default:    o_res.read_data = r_store[acc.reg_addr];
            endcase
        end else begin
            case (acc.reg_addr)
                ADDR_PORT_B: begin
                    n_pb = merge_bits(r_pb, acc.write_data, r_db);
                    if (!r_pb[PB_WRITE_BIT] && n_pb[PB_WRITE_BIT]) begin
                        o_res.speech_write_strobe = 1'b1;
                        o_res.speech_write_data   = r_pa;
                    end
                    // status fills the input bits, outputs keep their value
                    if (!r_pb[PB_READ_BIT] && n_pb[PB_READ_BIT]) begin
                        o_res.speech_read_strobe = 1'b1;
                        n_pa = merge_bits(acc.speech_status, r_pa, r_da);
                    end
                end
                ADDR_PORT_A, ADDR_PORT_A_ALT: begin
                    n_pa = merge_bits(r_pa, acc.write_data, r_da);
                end
                ADDR_DDR_B: n_db = acc.write_data;
                ADDR_DDR_A: n_da = acc.write_data;
                default:    n_store[acc.reg_addr] = acc.write_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb    <= REG_RESET;
            r_pa    <= REG_RESET;
            r_db    <= REG_RESET;
            r_da    <= REG_RESET;
            r_store <= {STORE_DEPTH{REG_RESET}};
        end else if (i_fire) begin
            r_pb    <= n_pb;
            r_pa    <= n_pa;
            r_db    <= n_db;
            r_da    <= n_da;
            r_store <= n_store;
        end
    end

endmodule

// ===== sv/vip_out_stage.sv =====
// result register of the port subset block with its stream handshake
// depends on vip_pkg
`timescale 1ns / 1ps

module vip_out_stage
    import vip_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_result                i_res,
    output logic                   o_advance,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    logic    r_valid;
    t_result r_res;

    // take a new result when the register is empty or being drained
    assign o_advance = i_valid && (!r_valid || i_tready);
    assign o_tvalid  = r_valid;
    assign o_tdata   = pack_result(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/vip_checker.sv =====
// port-level checks for the port subset block, bound to the top level
// depends on vip_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "versatile_interface_port_subset_assert.svh"

module vip_checker
    import vip_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [TUSER_W-1:0]     s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_result res;
    assign res = t_result'(m_axis_tdata[RES_W-1:0]);

    // no result word may survive reset
    `VIP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")

    // a stalled result holds still
    `VIP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // speech byte only travels with its strobe
    `VIP_ASSERT_NOW(a_wdata_gated, i_clk, i_rst_n, m_axis_tvalid && !res.speech_write_strobe, res.speech_write_data == 8'h00, "speech byte without strobe")

    // strobes come only from writes, which read back zero
    `VIP_ASSERT_NOW(a_strobe_write, i_clk, i_rst_n, m_axis_tvalid && (res.speech_write_strobe || res.speech_read_strobe), res.read_data == 8'h00, "strobe on a read access")

endmodule

bind versatile_interface_port_subset vip_checker u_vip_checker (.*);
